@@ design/rcbm_pkg.sv @@
// Shared types and constants for the region-checked byte memory.
// Command and status codes, region descriptor type, checker result type.
// No dependencies.
package rcbm_pkg;

   // Command codes carried in the request word
   typedef enum logic [1:0] {
      CMD_READ    = 2'd0,
      CMD_WRITE   = 2'd1,
      CMD_PRELOAD = 2'd2,
      CMD_NOP     = 2'd3
   } cmd_type;

   // Status codes carried in the response word
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_RANGE = 2'd1;
   localparam logic [1:0] STAT_VIOL  = 2'd2;

   // Access size codes; anything else means four bytes
   localparam logic [1:0] SIZE_BYTE = 2'd0;
   localparam logic [1:0] SIZE_HALF = 2'd1;

   localparam int LANES     = 4;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 36;
   localparam int CFG_COUNT = 4;

   // Decoded region: end is precomputed at write time (start + size, 18 bits)
   typedef struct packed {
      logic        en;
      logic        wr;
      logic        rd;
      logic [15:0] start;
      logic [17:0] stop;
   } region_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [LANES-1:0] byte_mask;   // bytes touched, by offset from addr
   } check_type;

   function automatic region_type region_decode(input logic [CSR_W-1:0] v);
      region_type r;
      r.start = v[15:0];
      r.stop  = 18'(v[15:0]) + 18'(v[32:16]);
      r.rd    = v[33];
      r.wr    = v[34];
      r.en    = v[35];
      return r;
   endfunction

endpackage

@@ design/region_checked_byte_memory.sv @@
// Region-checked byte memory, top level: region registers, banked byte store,
// clear sequencer and response register. Depends on rcbm_pkg and rcbm_check.
//
//   channel   dir   handshake              word
//   req_      in    tvalid/tready          cmd, access_size, addr, write_data
//   rsp_      out   tvalid/tready          read_data, status
//   csr_      in    wen (no wait)          index, wdata
//
// One request per cycle while not stalled; its response is presented the cycle
// after accept. Each of the four byte lanes is a one-port-per-direction RAM of
// 2^(ADDR_BITS-2) rows, registered read; any 1/2/4-byte access touches each lane
// at most once. After reset a clear pass zeroes one row of all lanes per cycle,
// through all 2^(ADDR_BITS-2) rows (16384 at ADDR_BITS = 16); req_tready stays
// low then. A stalled response holds the pipe; req_tready follows rsp_tready.
module region_checked_byte_memory #(
   parameter int ADDR_BITS   = 16,
   parameter int NUM_REGIONS = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [1:0] cmd, [3:2] access_size, [19:4] addr, [51:20] write_data
   input  logic [55:0]                    req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [31:0] read_data, [33:32] status
   output logic [39:0]                    rsp_tdata,
   input  logic                           csr_wen,
   input  logic [rcbm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rcbm_pkg::CSR_W-1:0]     csr_wdata
);
   import rcbm_pkg::*;

   localparam int ROW_W = ADDR_BITS - 2;
   localparam int ROWS  = 1 << ROW_W;

   logic [1:0]  req_cmd;
   logic [1:0]  req_size;
   logic [15:0] req_addr;
   logic [31:0] req_wdata;

   assign req_cmd   = req_tdata[1:0];
   assign req_size  = req_tdata[3:2];
   assign req_addr  = req_tdata[19:4];
   assign req_wdata = req_tdata[51:20];

   // ---------------- region registers
   region_type regions_ff [NUM_REGIONS];

   always_ff @(posedge clock) begin
      for (int r = 0; r < NUM_REGIONS; r++) begin
         if (reset) begin
            regions_ff[r] <= '0;
         end else if (csr_wen && r < CFG_COUNT && 32'(csr_index) == r) begin
            regions_ff[r] <= region_decode(csr_wdata);
         end
      end
   end

   // ---------------- checker
   check_type chk;

   rcbm_check #(
      .ADDR_BITS   (ADDR_BITS),
      .NUM_REGIONS (NUM_REGIONS)
   ) u_check (
      .regions     (regions_ff),
      .cmd         (req_cmd),
      .access_size (req_size),
      .addr        (req_addr),
      .result      (chk)
   );

   // ---------------- control
   logic             accept;
   logic             do_write;
   logic             do_read;
   logic             clearing_ff;
   logic [ROW_W-1:0] clear_row_ff;
   logic             rsp_valid_ff;

   assign req_tready = !clearing_ff && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign do_write   = accept && (req_cmd == CMD_WRITE || req_cmd == CMD_PRELOAD) &&
                       (chk.status == STAT_OK);
   assign do_read    = accept && (req_cmd == CMD_READ) && (chk.status == STAT_OK);

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clear_row_ff <= '0;
      end else if (clearing_ff) begin
         clear_row_ff <= clear_row_ff + 1'b1;
         if (&clear_row_ff) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   // ---------------- byte lanes
   logic [ROW_W-1:0] base_row;
   logic [1:0]       lane;
   logic [LANES-1:0] bank_we;
   logic [3:0][7:0]  bank_rdata;

   assign base_row = ROW_W'(req_addr >> 2);
   assign lane     = req_addr[1:0];

   for (genvar b = 0; b < LANES; b++) begin : g_bank
      logic [7:0]       mem [ROWS];
      logic [7:0]       rd_ff;
      logic [1:0]       ofs;
      logic             hit;
      logic [ROW_W-1:0] row;
      logic [7:0]       wbyte;
      logic [31:0]      wshift;

      assign ofs    = 2'(b) - lane;               // byte offset landing in this lane
      assign hit    = chk.byte_mask[ofs];
      assign row    = base_row + ROW_W'(2'(b) < lane);
      assign wshift = req_wdata >> {ofs, 3'b000};
      assign wbyte  = wshift[7:0];
      assign bank_we[b] = clearing_ff || (do_write && hit);

      always_ff @(posedge clock) begin
         if (clearing_ff) begin
            mem[clear_row_ff] <= '0;
         end else if (do_write && hit) begin
            mem[row] <= wbyte;
         end
         if (do_read && hit) begin
            rd_ff <= mem[row];
         end
      end

      assign bank_rdata[b] = rd_ff;
   end

   // ---------------- response register
   logic             use_mem_ff;
   logic [1:0]       lane_ff;
   logic [LANES-1:0] mask_ff;
   logic [31:0]      fixed_ff;
   logic [1:0]       status_ff;
   logic [31:0]      fixed_in;
   logic [31:0]      ones;

   assign ones = {{8{chk.byte_mask[3]}}, {8{chk.byte_mask[2]}},
                  {8{chk.byte_mask[1]}}, {8{chk.byte_mask[0]}}};
   // failed reads return all ones at the access width; writes return zero
   assign fixed_in = (req_cmd == CMD_READ && chk.status != STAT_OK) ? ones : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (accept) begin
         use_mem_ff <= do_read;
         lane_ff    <= lane;
         mask_ff    <= chk.byte_mask;
         fixed_ff   <= fixed_in;
         status_ff  <= chk.status;
      end
   end

   logic [31:0] read_word;

   always_comb begin
      logic [1:0] sel;
      for (int i = 0; i < LANES; i++) begin
         sel = lane_ff + 2'(i);
         read_word[8*i +: 8] = mask_ff[i] ? bank_rdata[sel] : 8'h00;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, status_ff, use_mem_ff ? read_word : fixed_ff};

`ifndef ASSERT_OFF
   a_no_accept_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !req_tready)
      else $error("request accepted during clear pass");

   a_rsp_follows_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted request produced no response");

   a_write_only_ok: assert property (@(posedge clock) disable iff (reset)
      (!clearing_ff && (|bank_we)) |-> (accept && chk.status == STAT_OK))
      else $error("byte store written by a failed access");

   a_fail_no_mem: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff != STAT_OK) |-> !use_mem_ff)
      else $error("failed access returned store data");
`endif

endmodule

@@ design/rcbm_check.sv @@
// Access checker: range check and per-byte region lookup for one request.
// Purely combinational; the top level registers around it.
// Depends on rcbm_pkg.
module rcbm_check #(
   parameter int ADDR_BITS   = 16,
   parameter int NUM_REGIONS = 4
) (
   input  rcbm_pkg::region_type regions [NUM_REGIONS],
   input  logic [1:0]           cmd,
   input  logic [1:0]           access_size,
   input  logic [15:0]          addr,
   output rcbm_pkg::check_type  result
);
   import rcbm_pkg::*;

   localparam int CMP_W = (ADDR_BITS > 16) ? ADDR_BITS + 1 : 17;

   logic [LANES-1:0] mask;
   logic [16:0]      last_addr;
   logic [CMP_W-1:0] last_ext;
   logic             out_of_range;
   logic             want_write;
   logic [LANES-1:0] byte_ok;
   logic             violation;

   always_comb begin
      case (access_size)
         SIZE_BYTE: mask = 4'b0001;
         SIZE_HALF: mask = 4'b0011;
         default:   mask = 4'b1111;
      endcase
   end

   always_comb begin
      case (access_size)
         SIZE_BYTE: last_addr = 17'(addr);
         SIZE_HALF: last_addr = 17'(addr) + 17'd1;
         default:   last_addr = 17'(addr) + 17'd3;
      endcase
   end

   assign last_ext     = CMP_W'(last_addr);
   assign out_of_range = |last_ext[CMP_W-1:ADDR_BITS];
   assign want_write   = (cmd == CMD_WRITE);

   // Lowest-numbered enabled region that covers the byte decides it
   always_comb begin
      logic [16:0] a;
      for (int i = 0; i < LANES; i++) begin
         a = 17'(addr) + 17'(i);
         byte_ok[i] = 1'b0;
         for (int r = NUM_REGIONS - 1; r >= 0; r--) begin
            if (regions[r].en && (a >= 17'(regions[r].start)) &&
                (18'(a) < regions[r].stop)) begin
               byte_ok[i] = want_write ? regions[r].wr : regions[r].rd;
            end
         end
      end
   end

   assign violation = |(mask & ~byte_ok);

   always_comb begin
      result.byte_mask = mask;
      if (cmd == CMD_NOP) begin
         result.status = STAT_VIOL;
      end else if (out_of_range) begin
         result.status = STAT_RANGE;
      end else if (cmd != CMD_PRELOAD && violation) begin
         result.status = STAT_VIOL;
      end else begin
         result.status = STAT_OK;
      end
   end

endmodule

@@ dv/tb_region_checked_byte_memory.sv @@
// Self-checking testbench for region_checked_byte_memory: directed table, then random phases.
// Each phase reprograms the four regions. Expected words come from an in-bench memory/region model.
// Depends on rcbm_pkg and the region_checked_byte_memory RTL.
module tb_region_checked_byte_memory;
   import rcbm_pkg::*;

   localparam logic [1:0] SIZE_WORD = 2'd2;
   localparam logic [1:0] SIZE_ODD  = 2'd3;   // decodes as four bytes
   localparam int MEM_BYTES       = 65536;
   localparam int RD_BIT          = 33;
   localparam int WR_BIT          = 34;
   localparam int EN_BIT          = 35;
   localparam int NUM_PHASES      = 10;
   localparam int ITEMS_PER_PHASE = 103;
   localparam int CYCLE_LIMIT     = 400000;

   typedef struct packed {
      logic [31:0] data;
      logic [15:0] addr;
      logic [1:0]  size;
      cmd_type     cmd;
   } mem_access_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic [1:0]  status;
   } mem_result_type;

   typedef struct {
      mem_access_type acc;
      bit             known;
      mem_result_type want;
   } script_row_type;

   logic                 clock;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [55:0]          req_tdata  = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b1;
   logic [39:0]          rsp_tdata;
   logic                 csr_wen    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [CSR_W-1:0]     csr_wdata  = '0;

   logic [7:0]       shadow_mem [MEM_BYTES];
   logic [CSR_W-1:0] region_shadow [CFG_COUNT];
   logic [CSR_W-1:0] phase_regions [CFG_COUNT];
   mem_result_type   expected_responses [$];
   mem_result_type   head_resp;
   script_row_type   directed_rows [$];
   int               mismatch_count = 0;
   int               req_idle_pct = 0;
   int               rsp_idle_pct = 0;
   int               rsp_hold = 0;

   region_checked_byte_memory dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("region_checked_byte_memory regression: fail");
      $finish;
   end

   function automatic logic [CSR_W-1:0] region_word(input logic en, input logic wr,
                                                    input logic rd, input logic [16:0] span,
                                                    input logic [15:0] start);
      return {en, wr, rd, span, start};
   endfunction

   function automatic int draw_wait(input int pct);
      return ($urandom_range(0, 99) < pct) ? $urandom_range(0, 18) : 0;
   endfunction

   // First enabled region holding the byte decides; unmapped bytes are refused.
   function automatic bit byte_permitted(input int b, input bit want_wr);
      int lo;
      int span;
      for (int r = 0; r < CFG_COUNT; r++) begin
         lo   = int'(region_shadow[r][15:0]);
         span = int'(region_shadow[r][32:16]);
         if (region_shadow[r][EN_BIT] && b >= lo && b < lo + span)
            return want_wr ? region_shadow[r][WR_BIT] : region_shadow[r][RD_BIT];
      end
      return 1'b0;
   endfunction

   function automatic mem_result_type predict_access(input mem_access_type a);
      mem_result_type r;
      int             nbytes;
      logic [31:0]    ones;
      nbytes = (a.size == SIZE_BYTE) ? 1 : (a.size == SIZE_HALF) ? 2 : 4;
      ones = (nbytes == 1) ? 32'h0000_00FF : (nbytes == 2) ? 32'h0000_FFFF : 32'hFFFF_FFFF;
      r.read_data = '0;
      r.status    = STAT_OK;
      if (a.cmd == CMD_NOP) begin
         r.status = STAT_VIOL;
      end else if (int'(a.addr) + nbytes > MEM_BYTES) begin
         r.status = STAT_RANGE;
      end else if (a.cmd != CMD_PRELOAD) begin
         for (int i = 0; i < nbytes; i++)
            if (!byte_permitted(int'(a.addr) + i, a.cmd == CMD_WRITE))
               r.status = STAT_VIOL;
      end
      if (a.cmd == CMD_READ) begin
         if (r.status != STAT_OK)
            r.read_data = ones;
         else
            for (int i = 0; i < nbytes; i++)
               r.read_data[8*i +: 8] = shadow_mem[int'(a.addr) + i];
      end else if (r.status == STAT_OK) begin
         for (int i = 0; i < nbytes; i++)
            shadow_mem[int'(a.addr) + i] = a.data[8*i +: 8];
      end
      return r;
   endfunction

   function automatic logic [CSR_W-1:0] draw_region();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return region_word(1'b1, 1'b1, 1'b1, 17'h10000, 16'h0000);
         default: return region_word($urandom_range(0, 4) != 0, 1'($urandom), 1'($urandom),
                     ($urandom_range(0, 3) == 0) ? 17'($urandom) : 17'($urandom_range(1, 600)),
                     16'($urandom));
      endcase
   endfunction

   // Addresses cluster on region edges, a small window at each region start and the
   // top of memory, so reads come back over earlier writes and accesses straddle boundaries.
   function automatic mem_access_type draw_access();
      mem_access_type   a;
      logic [CSR_W-1:0] rv;
      logic [17:0]      stop;
      int               pick;
      rv   = region_shadow[$urandom_range(0, CFG_COUNT-1)];
      stop = 18'(rv[15:0]) + 18'(rv[32:16]);
      pick = $urandom_range(0, 99);
      if (pick < 35)      a.addr = rv[15:0] + 16'($urandom_range(0, 63));
      else if (pick < 50) a.addr = rv[15:0] - 16'($urandom_range(1, 4));
      else if (pick < 70) a.addr = stop[15:0] - 16'($urandom_range(0, 5));
      else if (pick < 80) a.addr = 16'hFFFF - 16'($urandom_range(0, 5));
      else                a.addr = 16'($urandom);
      pick   = $urandom_range(0, 99);
      a.cmd  = (pick < 45) ? CMD_READ : (pick < 80) ? CMD_WRITE :
               (pick < 96) ? CMD_PRELOAD : CMD_NOP;
      a.size = 2'($urandom_range(0, 3));
      a.data = $urandom;
      return a;
   endfunction

   function automatic script_row_type fixed_row(input cmd_type c, input logic [1:0] sz,
                                                input logic [15:0] ad, input logic [31:0] d,
                                                input logic [31:0] rd, input logic [1:0] st);
      script_row_type row;
      row.acc  = '{data: d, addr: ad, size: sz, cmd: c};
      row.known = 1'b1;
      row.want = '{read_data: rd, status: st};
      return row;
   endfunction

   function automatic script_row_type model_row(input cmd_type c, input logic [1:0] sz,
                                                input logic [15:0] ad, input logic [31:0] d);
      script_row_type row;
      row.acc   = '{data: d, addr: ad, size: sz, cmd: c};
      row.known = 1'b0;
      row.want  = '0;
      return row;
   endfunction

   // Block must be idle here; one register per cycle.
   task automatic program_regions(input logic [CSR_W-1:0] vals [CFG_COUNT]);
      for (int i = 0; i < CFG_COUNT; i++) begin
         csr_wen   <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
         region_shadow[i] = vals[i];
      end
      csr_wen <= 1'b0;
   endtask

   // valid stays up across back-to-back words; it drops only for a drawn gap or a drain.
   task automatic issue_access(input mem_access_type acc, input bit known,
                               input mem_result_type want);
      int             gap;
      mem_result_type predicted;
      gap = draw_wait(req_idle_pct);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0000, acc.data, acc.addr, acc.size, acc.cmd};
      do @(posedge clock); while (req_tready !== 1'b1);
      predicted = predict_access(acc);
      expected_responses.insert(expected_responses.size(), known ? want : predicted);
   endtask

   task automatic drain_responses();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_responses.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (rsp_tvalid === 1'b1 && rsp_tready) begin
         if (expected_responses.size() == 0) begin
            $display("%0t: unexpected response word, expected none, got %h", $time, rsp_tdata);
            mismatch_count++;
         end else begin
            head_resp = expected_responses.pop_front();
            if (rsp_tdata[31:0] !== head_resp.read_data) begin
               $display("%0t: read_data expected %h got %h",
                        $time, head_resp.read_data, rsp_tdata[31:0]);
               mismatch_count++;
            end
            if (rsp_tdata[33:32] !== head_resp.status) begin
               $display("%0t: status expected %0d got %0d",
                        $time, head_resp.status, rsp_tdata[33:32]);
               mismatch_count++;
            end
         end
         rsp_hold = draw_wait(rsp_idle_pct);
         if (rsp_hold != 0) rsp_tready <= 1'b0;
      end else if (!rsp_tready) begin
         rsp_hold--;
         if (rsp_hold == 0) rsp_tready <= 1'b1;
      end
   end

   initial begin
      for (int i = 0; i < MEM_BYTES; i++) shadow_mem[i] = 8'h00;
      for (int i = 0; i < CFG_COUNT; i++) region_shadow[i] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // r0 rw low page, r1 read-only overlapping r0's top half, r2 rw top page,
      // r3 write-only with the largest size
      phase_regions = '{region_word(1'b1, 1'b1, 1'b1, 17'h00100, 16'h0000),
                        region_word(1'b1, 1'b0, 1'b1, 17'h00100, 16'h0080),
                        region_word(1'b1, 1'b1, 1'b1, 17'h00100, 16'hFF00),
                        region_word(1'b1, 1'b1, 1'b0, 17'h1FFFF, 16'h2000)};
      program_regions(phase_regions);

      directed_rows = '{
         fixed_row(CMD_READ,    SIZE_BYTE, 16'h0010, 32'h0000_0000, 32'h0000_0000, STAT_OK),
         fixed_row(CMD_READ,    SIZE_WORD, 16'h0000, 32'h0000_0000, 32'h0000_0000, STAT_OK),
         fixed_row(CMD_WRITE,   SIZE_WORD, 16'h0000, 32'hDEAD_BEEF, 32'h0000_0000, STAT_OK),
         model_row(CMD_READ,    SIZE_WORD, 16'h0000, 32'h0000_0000),
         model_row(CMD_READ,    SIZE_HALF, 16'h0001, 32'h0000_0000),
         model_row(CMD_READ,    SIZE_ODD,  16'h0000, 32'h0000_0000),
         fixed_row(CMD_WRITE,   SIZE_BYTE, 16'h0100, 32'h0000_00AA, 32'h0000_0000, STAT_VIOL),
         model_row(CMD_READ,    SIZE_BYTE, 16'h0100, 32'h0000_0000),
         fixed_row(CMD_WRITE,   SIZE_WORD, 16'h00FE, 32'h1122_3344, 32'h0000_0000, STAT_VIOL),
         model_row(CMD_READ,    SIZE_WORD, 16'h00FC, 32'h0000_0000),
         model_row(CMD_PRELOAD, SIZE_HALF, 16'h0100, 32'hFFFF_5A5A),
         model_row(CMD_READ,    SIZE_HALF, 16'h0100, 32'h0000_0000),
         model_row(CMD_READ,    SIZE_WORD, 16'hFFFC, 32'h0000_0000),
         model_row(CMD_WRITE,   SIZE_WORD, 16'hFFFC, 32'hFFFF_FFFF),
         fixed_row(CMD_READ,    SIZE_WORD, 16'hFFFD, 32'h0000_0000, 32'hFFFF_FFFF, STAT_RANGE),
         fixed_row(CMD_READ,    SIZE_HALF, 16'hFFFF, 32'h0000_0000, 32'h0000_FFFF, STAT_RANGE),
         model_row(CMD_READ,    SIZE_BYTE, 16'hFFFF, 32'h0000_0000),
         fixed_row(CMD_WRITE,   SIZE_ODD,  16'hFFFE, 32'h1234_5678, 32'h0000_0000, STAT_RANGE),
         fixed_row(CMD_PRELOAD, SIZE_WORD, 16'hFFFD, 32'hFFFF_FFFF, 32'h0000_0000, STAT_RANGE),
         fixed_row(CMD_READ,    SIZE_BYTE, 16'h2000, 32'h0000_0000, 32'h0000_00FF, STAT_VIOL),
         model_row(CMD_WRITE,   SIZE_HALF, 16'h2000, 32'h0000_BEEF),
         fixed_row(CMD_READ,    SIZE_BYTE, 16'h1000, 32'h0000_0000, 32'h0000_00FF, STAT_VIOL),
         fixed_row(CMD_NOP,     SIZE_WORD, 16'h0000, 32'hFFFF_FFFF, 32'h0000_0000, STAT_VIOL),
         model_row(CMD_READ,    SIZE_HALF, 16'h00FF, 32'h0000_0000)
      };
      req_idle_pct = 30;
      rsp_idle_pct = 30;
      foreach (directed_rows[k])
         issue_access(directed_rows[k].acc, directed_rows[k].known, directed_rows[k].want);

      for (int p = 0; p < NUM_PHASES; p++) begin
         drain_responses();
         req_idle_pct = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 30 : 100;
         rsp_idle_pct = (p % 4 == 1) ? 100 : (p % 4 == 2) ? 30 : 0;
         for (int i = 0; i < CFG_COUNT; i++)
            phase_regions[i] = (p == 0) ? '0 : (p == 1) ? '1 : draw_region();
         if (p == 2) phase_regions[0] = region_word(1'b1, 1'b1, 1'b1, 17'h10000, 16'h0000);
         program_regions(phase_regions);
         repeat (ITEMS_PER_PHASE) issue_access(draw_access(), 1'b0, '0);
      end

      drain_responses();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0)
         $display("region_checked_byte_memory regression: pass");
      else
         $display("region_checked_byte_memory regression: fail");
      $finish;
   end

endmodule

@@ files.f @@
design/rcbm_pkg.sv
design/rcbm_check.sv
design/region_checked_byte_memory.sv
dv/tb_region_checked_byte_memory.sv
